// ===== design/jtd_pkg.sv =====
package jtd_pkg;

    // field and datapath widths
    localparam int XW      = 8;    // stick position
    localparam int CW      = 16;   // Q1.14 rotation coefficient
    localparam int VW      = 9;    // velocity
    localparam int MW      = 16;   // shared multiplier operand
    localparam int PW      = 2 * MW;
    localparam int AW      = 25;   // rotation accumulator
    localparam int ROT_SHIFT = 10;
    localparam int RW      = AW - ROT_SHIFT;  // rotated component, 4 fraction bits
    localparam int SW      = 28;   // signed square, 8 fraction bits
    localparam int TW      = SW + 1;  // sum or difference of squares
    localparam int QW      = 28;   // root remainder and partial root
    localparam int BW      = 27;   // root bit, starts at 2**26
    localparam int ROOT_BITS = 14;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CW-1:0] RESET_COS = 16'd16135;
    localparam logic [CW-1:0] RESET_SIN = 16'd2845;
    localparam logic [7:0]    VEL_LIMIT = 8'd255;
    localparam logic [BW-1:0] ROOT_BIT_START = {1'b1, {(BW-1){1'b0}}};

    // register index, taken from paddr[2]
    localparam logic REG_COS = 1'b0;
    localparam logic REG_SIN = 1'b1;

    // multiplier schedule
    localparam logic [2:0] MS_XC  = 3'd0;
    localparam logic [2:0] MS_YS  = 3'd1;
    localparam logic [2:0] MS_XS  = 3'd2;
    localparam logic [2:0] MS_YC  = 3'd3;
    localparam logic [2:0] MS_SQX = 3'd4;
    localparam logic [2:0] MS_SQY = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

// ===== design/jtd_in_if.sv =====
interface jtd_in_if;
    import jtd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] stick_x;
    logic signed [XW-1:0] stick_y;
    logic                 reverse_button;

    modport source (output valid, output stick_x, output stick_y, output reverse_button,
                    input ready);
    modport sink   (input valid, input stick_x, input stick_y, input reverse_button,
                    output ready);
endinterface

// ===== design/jtd_out_if.sv =====
interface jtd_out_if;
    import jtd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] left_velocity;
    logic signed [VW-1:0] right_velocity;
    logic                 facing_forward;

    modport source (output valid, output left_velocity, output right_velocity,
                    output facing_forward, input ready);
    modport sink   (input valid, input left_velocity, input right_velocity,
                    input facing_forward, output ready);
endinterface

// ===== design/joystick_tank_drive_mixer_top.sv =====
// Tank-drive mixer: each stick word (x, y, reverse button) is rotated by the
// rot_cos/rot_sin offset (Q1.14, APB registers at 0x0 and 0x4), each rotated
// component is squared keeping its sign, and left/right velocities are the
// signed square roots of the sum and difference, rounded to whole percent and
// limited to +/-255. A press (0 to 1 edge) of the reverse button flips
// facing_forward, which comes out with the same word. Each accepted word makes
// six passes through one shared 16x16 multiplier for rotation and squaring,
// then goes through two square roots (each one load step and 14 steps of a
// single root unit retiring two radicand bits per cycle), then loads the
// output register. The block takes one word at a time and is ready again the
// cycle after the output register is loaded. A finished result may wait in
// the output register while the next word is accepted; if it is still
// waiting when the next result is done, the block holds until it is taken.
module joystick_tank_drive_mixer_top
    import jtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    jtd_in_if.sink             stick,
    jtd_out_if.source          drive,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    state_t               state_reg, state_next;
    logic [2:0]           mstep_reg, mstep_next;
    logic                 pass_reg, pass_next;
    logic                 button_prev_reg, button_prev_next;
    logic                 dir_reg, dir_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        cos_reg, sin_reg;

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [RW-1:0] rx_reg, rx_next;
    logic signed [RW-1:0] ry_reg, ry_next;
    logic signed [SW-1:0] sx_reg, sx_next;
    logic signed [SW-1:0] sy_reg, sy_next;
    logic [QW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        res_reg, res_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic                 neg_reg, neg_next;
    logic signed [VW-1:0] left_reg, left_next;
    logic signed [VW-1:0] right_reg, right_next;
    logic signed [VW-1:0] left_out_reg, left_out_next;
    logic signed [VW-1:0] right_out_reg, right_out_next;
    logic                 facing_out_reg, facing_out_next;

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [RW-1:0] abs_rx, abs_ry;
    logic signed [AW-1:0] rot_sum;

    // root unit
    logic [QW-1:0]        trial;
    logic                 fits;
    logic [QW-1:0]        res_step;
    logic [ROOT_BITS:0]   rounded;
    logic [10:0]          mag_pct;
    logic [7:0]           mag_sat;
    logic signed [VW-1:0] vel;
    logic signed [TW-1:0] radicand;
    logic [TW-1:0]        radicand_mag;

    logic accept_in;
    logic cfg_write;

    assign accept_in = stick.valid && stick.ready;
    assign stick.ready = (state_reg == ST_IDLE);
    assign drive.valid = out_valid_reg;
    assign drive.left_velocity = left_out_reg;
    assign drive.right_velocity = right_out_reg;
    assign drive.facing_forward = facing_out_reg;

    // APB
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SIN) ? {{(PDATA_W-CW){sin_reg[CW-1]}}, sin_reg}
                                          : {{(PDATA_W-CW){cos_reg[CW-1]}}, cos_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= RESET_COS;
            sin_reg <= RESET_SIN;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SIN)
                sin_reg <= pwdata[CW-1:0];
            else
                cos_reg <= pwdata[CW-1:0];
        end
    end

    assign abs_rx = rx_reg[RW-1] ? -rx_reg : rx_reg;
    assign abs_ry = ry_reg[RW-1] ? -ry_reg : ry_reg;

    always_comb
    begin
        mul_a = {{(MW-XW){x_reg[XW-1]}}, x_reg};
        mul_b = cos_reg;
        case (mstep_reg)
            MS_XC:
            begin
                mul_a = {{(MW-XW){x_reg[XW-1]}}, x_reg};
                mul_b = cos_reg;
            end
            MS_YS:
            begin
                mul_a = {{(MW-XW){y_reg[XW-1]}}, y_reg};
                mul_b = sin_reg;
            end
            MS_XS:
            begin
                mul_a = {{(MW-XW){x_reg[XW-1]}}, x_reg};
                mul_b = sin_reg;
            end
            MS_YC:
            begin
                mul_a = {{(MW-XW){y_reg[XW-1]}}, y_reg};
                mul_b = cos_reg;
            end
            MS_SQX:
            begin
                mul_a = {{(MW-RW){rx_reg[RW-1]}}, rx_reg};
                mul_b = {{(MW-RW){1'b0}}, abs_rx};
            end
            MS_SQY:
            begin
                mul_a = {{(MW-RW){ry_reg[RW-1]}}, ry_reg};
                mul_b = {{(MW-RW){1'b0}}, abs_ry};
            end
            default:
            begin
                mul_a = {{(MW-XW){x_reg[XW-1]}}, x_reg};
                mul_b = cos_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign rot_sum = (mstep_reg == MS_YS) ? acc_reg - prod[AW-1:0] : acc_reg + prod[AW-1:0];

    // one step of the digit-by-digit root
    assign trial = res_reg + {{(QW-BW){1'b0}}, bit_reg};
    assign fits = (rem_reg >= trial);
    assign res_step = fits ? (res_reg >> 1) + {{(QW-BW){1'b0}}, bit_reg} : (res_reg >> 1);

    // round half up to whole percent, then limit
    assign rounded = {1'b0, res_step[ROOT_BITS-1:0]} + (ROOT_BITS+1)'(8);
    assign mag_pct = {{(11-(ROOT_BITS-3)){1'b0}}, rounded[ROOT_BITS:4]};
    assign mag_sat = (mag_pct > {3'b000, VEL_LIMIT}) ? VEL_LIMIT : mag_pct[7:0];
    assign vel = neg_reg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

    assign radicand = pass_reg ? ($signed({sx_reg[SW-1], sx_reg}) - $signed({sy_reg[SW-1], sy_reg}))
                               : ($signed({sx_reg[SW-1], sx_reg}) + $signed({sy_reg[SW-1], sy_reg}));
    assign radicand_mag = radicand[TW-1] ? -radicand : radicand;

    always_comb
    begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        pass_next = pass_reg;
        button_prev_next = button_prev_reg;
        dir_next = dir_reg;
        out_valid_next = out_valid_reg;
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        neg_next = neg_reg;
        left_next = left_reg;
        right_next = right_reg;
        left_out_next = left_out_reg;
        right_out_next = right_out_reg;
        facing_out_next = facing_out_reg;

        if (drive.valid && drive.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    x_next = stick.stick_x;
                    y_next = stick.stick_y;
                    if (stick.reverse_button && !button_prev_reg)
                        dir_next = !dir_reg;
                    button_prev_next = stick.reverse_button;
                    mstep_next = MS_XC;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mstep_next = mstep_reg + 3'd1;
                case (mstep_reg)
                    MS_XC:  acc_next = prod[AW-1:0];
                    MS_YS:  rx_next = rot_sum[AW-1:ROT_SHIFT];
                    MS_XS:  acc_next = prod[AW-1:0];
                    MS_YC:  ry_next = rot_sum[AW-1:ROT_SHIFT];
                    MS_SQX: sx_next = prod[SW-1:0];
                    MS_SQY:
                    begin
                        sy_next = prod[SW-1:0];
                        pass_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_LOAD:
            begin
                neg_next = radicand[TW-1];
                rem_next = radicand_mag[QW-1:0];
                res_next = '0;
                bit_next = ROOT_BIT_START;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (fits)
                    rem_next = rem_reg - trial;
                res_next = res_step;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    if (pass_reg)
                    begin
                        right_next = vel;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        left_next = vel;
                        pass_next = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || drive.ready)
                begin
                    left_out_next = left_reg;
                    right_out_next = right_reg;
                    facing_out_next = dir_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mstep_reg <= MS_XC;
            pass_reg <= 1'b0;
            button_prev_reg <= 1'b0;
            dir_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mstep_reg <= mstep_next;
            pass_reg <= pass_next;
            button_prev_reg <= button_prev_next;
            dir_reg <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        neg_reg <= neg_next;
        left_reg <= left_next;
        right_reg <= right_next;
        left_out_reg <= left_out_next;
        right_out_reg <= right_out_next;
        facing_out_reg <= facing_out_next;
    end

    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == ST_MUL) && (mstep_reg == MS_XC))
        else $error("accepted word did not start the multiply sequence");

    a_press_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && stick.reverse_button && !button_prev_reg |=> dir_reg != $past(dir_reg))
        else $error("button press did not flip direction");

    a_root_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> $onehot(bit_reg))
        else $error("root bit lost");

    a_vel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid |-> (left_out_reg != 9'h100) && (right_out_reg != 9'h100))
        else $error("velocity outside limit");

endmodule
